// File: rtl/pfe_pkg.sv
// Shared types, constants and helpers of the printf format engine.
package pfe_pkg;

  localparam int STR_BUF   = 32;
  localparam int SAW       = $clog2(STR_BUF);
  localparam int SLW       = $clog2(STR_BUF + 1);
  localparam int WIDTH_MAX = 63;
  localparam int PREC_CAP  = 63;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    OP_FMT  = 2'd0,
    OP_INT  = 2'd1,
    OP_SCHR = 2'd2,
    OP_SEND = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_ERR   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] value;
    logic        is_digit;
    logic [3:0]  digit;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [15:0] count;
    logic        last;
  } res_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'b0, d};
    else if (upper) c = 8'h41 + {4'b0, d} - 8'd10;
    else c = 8'h61 + {4'b0, d} - 8'd10;
    return c;
  endfunction

endpackage

// File: rtl/pfe_if.sv
// Valid/ready channel interfaces for input items and result words.
interface pfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] value;
  modport source (output valid, opcode, value, input ready);
  modport sink (input valid, opcode, value, output ready);
endinterface

interface pfe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_char;
  logic [15:0] char_count;
  logic        last;
  modport source (output valid, kind, out_char, char_count, last, input ready);
  modport sink (input valid, kind, out_char, char_count, last, output ready);
endinterface

// File: rtl/printf_format_engine.sv
// Path: an accepted word goes into the queue, then into the back end's current-word
// register; a plain character result passes the held-result and output registers.
// The back end takes one word at a time and waits while the output is stalled; string
// and digit characters are read from the string store, decimal digits come from the
// reciprocal multiplier (S_DIV1, S_DIV2), octal and hex digits from shifts (S_DSH).
// Reset: asynchronous, active low; clears queue, phase, format flags and count.
module printf_format_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfe_in_if.sink     in_i,
  pfe_out_if.source  out_o
);

  // classified words queue up so input acceptance does not wait on the back end while the queue has room
  logic           push, q_full, q_empty, pop;
  pfe_pkg::item_t push_item, pop_item;

  pfe_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item)
  );

  pfe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_item),
    .empty_o     (q_empty)
  );

  // back end owns the format state, the digit unit and the output register
  pfe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (pop_item),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

// File: rtl/pfe_queue.sv
// Small FIFO of classified items between front and back.
module pfe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pfe_pkg::item_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output pfe_pkg::item_t  pop_data_o,
  output logic            empty_o
);

  pfe_pkg::item_t            mem_q [pfe_pkg::QDEPTH];
  logic [pfe_pkg::QAW-1:0]   wr_q, rd_q;
  logic [pfe_pkg::QAW:0]     cnt_q;

  assign full_o     = (cnt_q == (pfe_pkg::QAW+1)'(pfe_pkg::QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: rtl/pfe_front.sv
// Front end: accepts input words and pre-decodes the character.
module pfe_front (
  pfe_in_if.sink          in_i,
  input  logic            q_full_i,
  output logic            push_o,
  output pfe_pkg::item_t  item_o
);

  logic [7:0] ch_off;

  assign ch_off      = in_i.value[7:0] - 8'h30;
  assign in_i.ready  = !q_full_i;
  assign push_o      = in_i.valid && !q_full_i;

  always_comb begin
    item_o.opcode   = in_i.opcode;
    item_o.value    = in_i.value;
    item_o.is_digit = (ch_off < 8'd10);
    item_o.digit    = ch_off[3:0];
  end

endmodule

// File: rtl/pfe_back.sv
// Back end: format sequencer, digit unit, string store and result register.
module pfe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  pfe_pkg::item_t  q_data_i,
  output logic            pop_o,
  pfe_out_if.source       out_o
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_DIV1  = 4'd2;
  localparam logic [3:0] S_DIV2  = 4'd3;
  localparam logic [3:0] S_DSH   = 4'd4;
  localparam logic [3:0] S_PREP  = 4'd5;
  localparam logic [3:0] S_SPRE  = 4'd6;
  localparam logic [3:0] S_PADL  = 4'd7;
  localparam logic [3:0] S_SPOST = 4'd8;
  localparam logic [3:0] S_BODYA = 4'd9;
  localparam logic [3:0] S_BODYB = 4'd10;
  localparam logic [3:0] S_PADR  = 4'd11;
  localparam logic [3:0] S_UNK   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  // format phases
  localparam logic [3:0] PH_TEXT   = 4'd0;
  localparam logic [3:0] PH_MINUS  = 4'd1;
  localparam logic [3:0] PH_ZERO   = 4'd2;
  localparam logic [3:0] PH_WSTART = 4'd3;
  localparam logic [3:0] PH_WDIG   = 4'd4;
  localparam logic [3:0] PH_WARG   = 4'd5;
  localparam logic [3:0] PH_DOT    = 4'd6;
  localparam logic [3:0] PH_PSTART = 4'd7;
  localparam logic [3:0] PH_PDIG   = 4'd8;
  localparam logic [3:0] PH_PARG   = 4'd9;
  localparam logic [3:0] PH_LONG   = 4'd10;
  localparam logic [3:0] PH_KEY    = 4'd11;
  localparam logic [3:0] PH_IARG   = 4'd12;
  localparam logic [3:0] PH_STR    = 4'd13;

  localparam logic [2:0] CV_D  = 3'd0;
  localparam logic [2:0] CV_U  = 3'd1;
  localparam logic [2:0] CV_O  = 3'd2;
  localparam logic [2:0] CV_XL = 3'd3;
  localparam logic [2:0] CV_XU = 3'd4;
  localparam logic [2:0] CV_C  = 3'd5;
  localparam logic [2:0] CV_S  = 3'd6;

  localparam logic [1:0] SRC_ASC  = 2'd0;
  localparam logic [1:0] SRC_DESC = 2'd1;
  localparam logic [1:0] SRC_ONE  = 2'd2;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam int SAW = pfe_pkg::SAW;
  localparam int SLW = pfe_pkg::SLW;

  logic [3:0]  st_q, st_d, phase_q, phase_d;
  logic        left_q, left_d, zero_q, zero_d, punl_q, punl_d;
  logic [5:0]  fw_q, fw_d, prec_q, prec_d;
  logic [2:0]  conv_q, conv_d;
  logic [SLW-1:0] slen_q, slen_d, zlen_q, zlen_d;
  logic        zseen_q, zseen_d;
  logic [15:0] cnt_q, cnt_d;
  pfe_pkg::item_t cur_q, cur_d;
  logic [31:0] u_q, u_d;
  logic [63:0] prod_q;
  logic [3:0]  ndig_q, ndig_d;
  logic        neg_q, neg_d;
  logic [5:0]  len_q, len_d, pad_q, pad_d;
  logic [SAW-1:0] bidx_q, bidx_d;
  logic [1:0]  bsrc_q, bsrc_d;
  logic [7:0]  bchr_q, bchr_d;
  logic        pend_v_q, pend_v_d, out_v_q, out_v_d;
  pfe_pkg::res_t pend_q, pend_d, out_q, out_d;

  logic [7:0]  mem_q [pfe_pkg::STR_BUF];
  logic [7:0]  rd_q;
  logic        mem_we;
  logic [SAW-1:0] mem_wa;
  logic [7:0]  mem_wd;

  logic        out_free, can_emit, emit_req, flush_req, clr_spec;
  pfe_pkg::res_t emit_res;
  logic [7:0]  ch;
  logic        op_ok;
  logic [9:0]  acc;
  logic [28:0] quo;
  logic [31:0] rem;
  logic [3:0]  dv;
  logic [4:0]  total;
  logic [5:0]  ulen;
  logic [7:0]  padv;
  logic [31:0] negv;

  function automatic logic [5:0] cut(input logic [5:0] l, input logic unl,
                                     input logic [5:0] p);
    return (!unl && l > p) ? p : l;
  endfunction

  assign out_free = !out_v_q || out_o.ready;
  assign can_emit = !pend_v_q || out_free;
  assign ch       = cur_q.value[7:0];
  assign pop_o    = (st_q == S_IDLE) && !q_empty_i;
  assign quo      = prod_q[63:35];
  assign rem      = u_q - ({quo, 3'b0} + {2'b0, quo, 1'b0});
  assign negv     = 32'd0 - cur_q.value;

  assign out_o.valid      = out_v_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.out_char   = out_q.ch;
  assign out_o.char_count = out_q.count;
  assign out_o.last       = out_q.last;

  always_comb begin
    st_d = st_q; phase_d = phase_q; left_d = left_q; zero_d = zero_q;
    punl_d = punl_q; fw_d = fw_q; prec_d = prec_q; conv_d = conv_q;
    slen_d = slen_q; zlen_d = zlen_q; zseen_d = zseen_q; cnt_d = cnt_q;
    cur_d = cur_q; u_d = u_q; ndig_d = ndig_q; neg_d = neg_q; len_d = len_q;
    pad_d = pad_q; bidx_d = bidx_q; bsrc_d = bsrc_q; bchr_d = bchr_q;
    emit_req = 1'b0; emit_res = '0; flush_req = 1'b0; clr_spec = 1'b0;
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0;
    acc = '0; dv = '0; total = '0; ulen = '0; padv = '0;

    if (phase_q == PH_WARG || phase_q == PH_PARG || phase_q == PH_IARG)
      op_ok = (cur_q.opcode == pfe_pkg::OP_INT);
    else if (phase_q == PH_STR)
      op_ok = (cur_q.opcode == pfe_pkg::OP_SCHR) || (cur_q.opcode == pfe_pkg::OP_SEND);
    else
      op_ok = (cur_q.opcode == pfe_pkg::OP_FMT);

    unique case (st_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          cur_d = q_data_i;
          st_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_emit) begin
          if (!op_ok) begin
            emit_req = 1'b1;
            emit_res.kind = pfe_pkg::KIND_ERR;
            st_d = S_FIN;
          end else begin
            unique case (phase_q)
              PH_WARG: begin
                if (cur_q.value[31]) fw_d = '0;
                else if (cur_q.value > 32'(pfe_pkg::WIDTH_MAX)) fw_d = 6'(pfe_pkg::WIDTH_MAX);
                else fw_d = cur_q.value[5:0];
                phase_d = PH_DOT;
                st_d = S_FIN;
              end
              PH_PARG: begin
                if (cur_q.value[31]) prec_d = '0;
                else if (cur_q.value > 32'(pfe_pkg::PREC_CAP)) prec_d = 6'(pfe_pkg::PREC_CAP);
                else prec_d = cur_q.value[5:0];
                punl_d = 1'b0;
                phase_d = PH_LONG;
                st_d = S_FIN;
              end
              PH_IARG: begin
                if (conv_q == CV_C) begin
                  bchr_d = ch; bsrc_d = SRC_ONE; len_d = 6'd1; neg_d = 1'b0;
                  st_d = S_PREP;
                end else begin
                  neg_d  = (conv_q == CV_D) && cur_q.value[31];
                  u_d    = ((conv_q == CV_D) && cur_q.value[31]) ? negv : cur_q.value;
                  ndig_d = '0;
                  st_d   = (conv_q == CV_D || conv_q == CV_U) ? S_DIV1 : S_DSH;
                end
              end
              PH_STR: begin
                if (cur_q.opcode == pfe_pkg::OP_SCHR) begin
                  if (slen_q < SLW'(pfe_pkg::STR_BUF)) begin
                    mem_we = 1'b1; mem_wa = slen_q[SAW-1:0]; mem_wd = ch;
                    if (ch == 8'h00 && !zseen_q) begin
                      zseen_d = 1'b1; zlen_d = slen_q;
                    end
                    slen_d = slen_q + 1'b1;
                  end
                  st_d = S_FIN;
                end else begin
                  len_d  = cut(6'(zseen_q ? zlen_q : slen_q), punl_q, prec_q);
                  bidx_d = '0; bsrc_d = SRC_ASC; neg_d = 1'b0;
                  st_d   = S_PREP;
                end
              end
              PH_TEXT: begin
                if (ch == 8'h00) begin
                  emit_req = 1'b1; emit_res.kind = pfe_pkg::KIND_COUNT;
                  emit_res.count = cnt_q; cnt_d = '0; clr_spec = 1'b1;
                  phase_d = PH_TEXT;
                end else if (ch == CH_PCT) begin
                  clr_spec = 1'b1; phase_d = PH_MINUS;
                end else begin
                  emit_req = 1'b1; emit_res.kind = pfe_pkg::KIND_CHAR; emit_res.ch = ch;
                end
                st_d = S_FIN;
              end
              PH_MINUS: begin
                phase_d = PH_ZERO;
                if (ch == CH_MINUS) begin left_d = 1'b1; st_d = S_FIN; end
              end
              PH_ZERO: begin
                phase_d = PH_WSTART;
                if (ch == CH_ZERO) begin zero_d = 1'b1; st_d = S_FIN; end
              end
              PH_WSTART: begin
                if (ch == CH_STAR) begin phase_d = PH_WARG; st_d = S_FIN; end
                else phase_d = PH_WDIG;
              end
              PH_WDIG: begin
                if (cur_q.is_digit) begin
                  acc = 10'(fw_q) * 10'd10 + 10'(cur_q.digit);
                  fw_d = (acc > 10'(pfe_pkg::WIDTH_MAX)) ? 6'(pfe_pkg::WIDTH_MAX) : acc[5:0];
                  st_d = S_FIN;
                end else phase_d = PH_DOT;
              end
              PH_DOT: begin
                if (ch == CH_DOT) begin phase_d = PH_PSTART; st_d = S_FIN; end
                else phase_d = PH_LONG;
              end
              PH_PSTART: begin
                if (ch == CH_STAR) begin
                  phase_d = PH_PARG; st_d = S_FIN;
                end else if (cur_q.is_digit) begin
                  prec_d = 6'(cur_q.digit); punl_d = 1'b0; phase_d = PH_PDIG; st_d = S_FIN;
                end else phase_d = PH_LONG;
              end
              PH_PDIG: begin
                if (cur_q.is_digit) begin
                  acc = 10'(prec_q) * 10'd10 + 10'(cur_q.digit);
                  prec_d = (acc > 10'(pfe_pkg::PREC_CAP)) ? 6'(pfe_pkg::PREC_CAP) : acc[5:0];
                  st_d = S_FIN;
                end else phase_d = PH_LONG;
              end
              PH_LONG: begin
                phase_d = PH_KEY;
                if (ch == 8'h6C || ch == 8'h4C) st_d = S_FIN;
              end
              PH_KEY: begin
                st_d = S_FIN;
                priority case (ch)
                  8'h00: begin
                    emit_req = 1'b1; emit_res.kind = pfe_pkg::KIND_COUNT;
                    emit_res.count = cnt_q; cnt_d = '0; clr_spec = 1'b1;
                    phase_d = PH_TEXT;
                  end
                  8'h64: begin conv_d = CV_D; phase_d = PH_IARG; end
                  8'h75: begin conv_d = CV_U; phase_d = PH_IARG; end
                  8'h6F: begin conv_d = CV_O; phase_d = PH_IARG; end
                  8'h78: begin conv_d = CV_XL; phase_d = PH_IARG; end
                  8'h58, 8'h70: begin conv_d = CV_XU; phase_d = PH_IARG; end
                  8'h63: begin conv_d = CV_C; phase_d = PH_IARG; end
                  8'h73: begin
                    conv_d = CV_S; slen_d = '0; zseen_d = 1'b0; zlen_d = '0;
                    phase_d = PH_STR;
                  end
                  CH_PCT: begin
                    bchr_d = CH_PCT; bsrc_d = SRC_ONE; len_d = 6'd1; neg_d = 1'b0;
                    st_d = S_PREP;
                  end
                  default: begin
                    emit_req = 1'b1; emit_res.kind = pfe_pkg::KIND_CHAR;
                    emit_res.ch = CH_PCT;
                    st_d = S_UNK;
                  end
                endcase
              end
              default: st_d = S_FIN;
            endcase
          end
        end
      end
      S_DIV1: st_d = S_DIV2;
      S_DIV2, S_DSH: begin
        if (st_q == S_DIV2) begin
          dv = rem[3:0]; u_d = {3'b0, quo};
        end else if (conv_q == CV_O) begin
          dv = {1'b0, u_q[2:0]}; u_d = u_q >> 3;
        end else begin
          dv = u_q[3:0]; u_d = u_q >> 4;
        end
        mem_we = 1'b1; mem_wa = SAW'(ndig_q);
        mem_wd = pfe_pkg::digit_char(dv, conv_q == CV_XU);
        ndig_d = ndig_q + 1'b1;
        if (u_d == '0) begin
          total  = {1'b0, ndig_q} + 5'd1;
          ulen   = 6'(total);
          len_d  = cut(ulen, punl_q, prec_q);
          bidx_d = SAW'(ndig_q);
          bsrc_d = SRC_DESC;
          st_d   = S_PREP;
        end else begin
          st_d = (st_q == S_DIV2) ? S_DIV1 : S_DSH;
        end
      end
      S_PREP: begin
        padv  = {2'b0, fw_q} - {2'b0, len_q} - {7'b0, neg_q};
        pad_d = (!padv[7] && padv != '0) ? padv[5:0] : '0;
        st_d  = S_SPRE;
      end
      S_SPRE: begin
        if (zero_q && neg_q) begin
          if (can_emit) begin
            emit_req = 1'b1; emit_res.ch = CH_MINUS; st_d = S_PADL;
          end
        end else st_d = S_PADL;
      end
      S_PADL: begin
        if (!left_q && pad_q != '0) begin
          if (can_emit) begin
            emit_req = 1'b1; emit_res.ch = zero_q ? CH_ZERO : CH_SPACE;
            pad_d = pad_q - 1'b1;
          end
        end else st_d = S_SPOST;
      end
      S_SPOST: begin
        if (!zero_q && neg_q) begin
          if (can_emit) begin
            emit_req = 1'b1; emit_res.ch = CH_MINUS; st_d = S_BODYA;
          end
        end else st_d = S_BODYA;
      end
      S_BODYA: begin
        if (len_q == '0) st_d = S_PADR;
        else if (bsrc_q == SRC_ONE) begin
          if (can_emit) begin
            emit_req = 1'b1; emit_res.ch = bchr_q; len_d = len_q - 1'b1;
          end
        end else st_d = S_BODYB;
      end
      S_BODYB: begin
        if (can_emit) begin
          emit_req = 1'b1; emit_res.ch = rd_q; len_d = len_q - 1'b1;
          bidx_d = (bsrc_q == SRC_DESC) ? bidx_q - 1'b1 : bidx_q + 1'b1;
          st_d = S_BODYA;
        end
      end
      S_PADR: begin
        if (pad_q != '0) begin
          if (can_emit) begin
            emit_req = 1'b1; emit_res.ch = zero_q ? CH_ZERO : CH_SPACE;
            pad_d = pad_q - 1'b1;
          end
        end else begin
          phase_d = PH_TEXT; clr_spec = 1'b1; st_d = S_FIN;
        end
      end
      S_UNK: begin
        if (can_emit) begin
          emit_req = 1'b1; emit_res.ch = ch;
          phase_d = PH_TEXT; clr_spec = 1'b1; st_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!pend_v_q) st_d = S_IDLE;
        else if (out_free) begin
          flush_req = 1'b1; st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase

    if (clr_spec) begin
      left_d = 1'b0; zero_d = 1'b0; fw_d = '0; prec_d = '0; punl_d = 1'b1; conv_d = CV_D;
    end

    if (emit_req && emit_res.kind == pfe_pkg::KIND_CHAR && cnt_q != 16'hFFFF)
      cnt_d = cnt_q + 1'b1;

    // one result is held back until it is known whether it ends the word's run
    out_v_d = out_v_q && !out_o.ready;
    out_d = out_q; pend_d = pend_q; pend_v_d = pend_v_q;
    if (emit_req) begin
      if (pend_v_q) begin
        out_d = pend_q; out_d.last = 1'b0; out_v_d = 1'b1;
      end
      pend_d = emit_res; pend_v_d = 1'b1;
    end else if (flush_req) begin
      out_d = pend_q; out_d.last = 1'b1; out_v_d = 1'b1; pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[bidx_q];
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;  u_q <= u_d;  prod_q <= u_q * pfe_pkg::RECIP10;
    neg_q  <= neg_d;  len_q <= len_d;  pad_q <= pad_d;  bidx_q <= bidx_d;
    bsrc_q <= bsrc_d; bchr_q <= bchr_d; pend_q <= pend_d; out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; phase_q <= PH_TEXT; left_q <= 1'b0; zero_q <= 1'b0;
      punl_q <= 1'b1; fw_q <= '0; prec_q <= '0; conv_q <= CV_D;
      slen_q <= '0; zlen_q <= '0; zseen_q <= 1'b0; cnt_q <= '0; ndig_q <= '0;
      pend_v_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; phase_q <= phase_d; left_q <= left_d; zero_q <= zero_d;
      punl_q <= punl_d; fw_q <= fw_d; prec_q <= prec_d; conv_q <= conv_d;
      slen_q <= slen_d; zlen_q <= zlen_d; zseen_q <= zseen_d; cnt_q <= cnt_d;
      ndig_q <= ndig_d; pend_v_q <= pend_v_d; out_v_q <= out_v_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> !pend_v_q) else $error("held result left at idle");
  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndig_q <= 4'd11) else $error("digit count overflow");
  a_slen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slen_q <= SLW'(pfe_pkg::STR_BUF)) else $error("string length overflow");
`endif

endmodule
